// File: sv/rfa_pkg.sv
// Shared types and constants for the rational fraction ALU.
// Operation codes, sequencing selects and the controller/datapath command bundle.
// No dependencies.
`default_nettype none

package rfa_pkg;

  localparam int FIELD_BITS        = 32;
  localparam int OP_BITS           = 4;
  localparam int S_DATA_BITS       = 4 * FIELD_BITS;
  localparam int M_DATA_BITS       = 72;
  localparam int M_PAD_BITS        = M_DATA_BITS - 2 * FIELD_BITS - 1;
  localparam int WORD_BITS_DEFAULT = 32;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_GT     = 4'd4,
    OP_LT     = 4'd5,
    OP_EQ     = 4'd6,
    OP_NE     = 4'd7,
    OP_REDUCE = 4'd8,
    OP_INC    = 4'd9,
    OP_DEC    = 4'd10,
    OP_TO_INT = 4'd11
  } rfa_op_t;

  // multiplier operand pairs; each product has its own result register
  typedef enum logic [1:0] {
    MS_AN_BD,
    MS_BN_AD,
    MS_AD_BD,
    MS_AN_BN
  } mul_sel_t;

  // divider operand pairs and where the result goes
  typedef enum logic [2:0] {
    DS_XY,
    DS_AN_G,
    DS_AD_G,
    DS_BN_G,
    DS_BD_G,
    DS_AN_AD
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL_GO,
    S_MUL_WAIT,
    S_EUC_INIT,
    S_EUC_TEST,
    S_STEP_WAIT,
    S_QN_WAIT,
    S_QD_WAIT,
    S_INT_WAIT,
    S_DONE
  } rfa_state_t;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     div_go;
    div_sel_t div_sel;
    logic     euc_init;
    logic     euc_side;
    logic     capture;
  } rfa_cmd_t;

  typedef struct packed {
    logic               mul_done;
    logic               div_done;
    logic               y_zero;
    logic [OP_BITS-1:0] op;
  } rfa_status_t;

endpackage

`default_nettype wire

// File: sv/rfa_mul.sv
// Iterative shift-add multiplier, one multiplier bit per cycle, low word kept.
// Uses no package items.
`default_nettype none

module rfa_mul #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  output logic                 done,
  output logic [WORD_BITS-1:0] prod
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] mcand;
  logic [WORD_BITS-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc    <= '0;
      mcand  <= a;
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;

endmodule

`default_nettype wire

// File: sv/rfa_div.sv
// Iterative signed truncating divider: restoring, one quotient bit per cycle,
// then a sign fix step. A zero divisor gives zero quotient and remainder.
// Uses no package items.
`default_nettype none

module rfa_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 done,
  output logic [WORD_BITS-1:0] quot,
  output logic [WORD_BITS-1:0] rem
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic                 busy;
  logic                 fix;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] mb;
  logic [WORD_BITS-1:0] q;
  logic [WORD_BITS-1:0] r;
  logic                 neg_q;
  logic                 neg_r;
  logic [WORD_BITS:0]   trial;
  logic                 fits;

  function automatic logic [WORD_BITS-1:0] mag(input logic [WORD_BITS-1:0] v);
    return v[WORD_BITS-1] ? (~v + 1'b1) : v;
  endfunction

  assign trial = {r, q[WORD_BITS-1]};
  assign fits  = trial >= {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        if (divisor == '0) begin
          fix <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CW'(WORD_BITS);
        end
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      mb <= mag(divisor);
      r  <= '0;
      if (divisor == '0) begin
        q     <= '0;
        neg_q <= 1'b0;
        neg_r <= 1'b0;
      end else begin
        q     <= mag(dividend);
        neg_q <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        neg_r <= dividend[WORD_BITS-1];
      end
    end else if (busy) begin
      r <= fits ? WORD_BITS'(trial - {1'b0, mb}) : trial[WORD_BITS-1:0];
      q <= {q[WORD_BITS-2:0], fits};
    end else if (fix) begin
      quot <= neg_q ? (~q + 1'b1) : q;
      rem  <= neg_r ? (~r + 1'b1) : r;
    end
  end

endmodule

`default_nettype wire

// File: sv/rfa_datapath.sv
// Datapath: operand and product registers, Euclid registers, shared multiplier
// and divider, result selection and output register. Depends on rfa_pkg,
// rfa_mul and rfa_div.
`default_nettype none

module rfa_datapath #(
  parameter int WORD_BITS = rfa_pkg::WORD_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  rfa_pkg::rfa_cmd_t                    cmd,
  output rfa_pkg::rfa_status_t                 status,
  input  logic [rfa_pkg::OP_BITS-1:0]          operation,
  input  logic signed [rfa_pkg::FIELD_BITS-1:0] a_num,
  input  logic signed [rfa_pkg::FIELD_BITS-1:0] a_den,
  input  logic signed [rfa_pkg::FIELD_BITS-1:0] b_num,
  input  logic signed [rfa_pkg::FIELD_BITS-1:0] b_den,
  output logic signed [rfa_pkg::FIELD_BITS-1:0] res_num,
  output logic signed [rfa_pkg::FIELD_BITS-1:0] res_den,
  output logic                                 truth,
  output logic                                 error
);

  import rfa_pkg::*;

  localparam int W = WORD_BITS;

  logic [OP_BITS-1:0] op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic signed [W-1:0] p_anbd, p_bnad, p_adbd, p_anbn;
  logic signed [W-1:0] x, y;
  logic signed [W-1:0] ra_n, ra_d, rb_n, rb_d;
  logic signed [W-1:0] q_int;
  mul_sel_t            mul_dst;
  div_sel_t            div_dst;

  logic [W-1:0] mul_a, mul_b, mul_p;
  logic [W-1:0] div_n, div_d, div_q, div_r;
  logic         mul_done, div_done;

  logic signed [W-1:0] a_num_w, a_den_w, b_num_w, b_den_w;

  logic signed [W-1:0] rn, rd;
  logic                tr, er, both, eqv, gtv;

  assign a_num_w = W'(a_num);
  assign a_den_w = W'(a_den);
  assign b_num_w = W'(b_num);
  assign b_den_w = W'(b_den);

  always_comb begin
    unique case (cmd.mul_sel)
      MS_AN_BD: begin mul_a = an; mul_b = bd; end
      MS_BN_AD: begin mul_a = bn; mul_b = ad; end
      MS_AD_BD: begin mul_a = ad; mul_b = bd; end
      MS_AN_BN: begin mul_a = an; mul_b = bn; end
    endcase
  end

  always_comb begin
    unique case (cmd.div_sel)
      DS_XY:    begin div_n = x;  div_d = y;  end
      DS_AN_G:  begin div_n = an; div_d = x;  end
      DS_AD_G:  begin div_n = ad; div_d = x;  end
      DS_BN_G:  begin div_n = bn; div_d = x;  end
      DS_BD_G:  begin div_n = bd; div_d = x;  end
      DS_AN_AD: begin div_n = an; div_d = ad; end
      default:  begin div_n = x;  div_d = y;  end
    endcase
  end

  rfa_mul #(.WORD_BITS(W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_p)
  );

  rfa_div #(.WORD_BITS(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // subtract is add with b's denominator negated
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      an <= a_num_w;
      ad <= a_den_w;
      bn <= b_num_w;
      bd <= (operation == OP_SUB) ? -b_den_w : b_den_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      mul_dst <= cmd.mul_sel;
    end
    if (mul_done) begin
      unique case (mul_dst)
        MS_AN_BD: p_anbd <= mul_p;
        MS_BN_AD: p_bnad <= mul_p;
        MS_AD_BD: p_adbd <= mul_p;
        MS_AN_BN: p_anbn <= mul_p;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      div_dst <= cmd.div_sel;
    end
    if (cmd.euc_init) begin
      x <= cmd.euc_side ? bn : an;
      y <= cmd.euc_side ? bd : ad;
    end else if (div_done) begin
      unique case (div_dst)
        DS_XY: begin
          x <= y;
          y <= div_r;
        end
        DS_AN_G:  ra_n  <= div_q;
        DS_AD_G:  ra_d  <= div_q;
        DS_BN_G:  rb_n  <= div_q;
        DS_BD_G:  rb_d  <= div_q;
        DS_AN_AD: q_int <= div_q;
        default: ;
      endcase
    end
  end

  assign both = (ad == '0) || (bd == '0);
  assign eqv  = (ra_n == rb_n) && (ra_d == rb_d);
  assign gtv  = p_anbd > p_bnad;

  always_comb begin
    rn = '0;
    rd = W'(1);
    tr = 1'b0;
    er = 1'b0;
    unique case (op)
      OP_ADD, OP_SUB: begin
        rn = p_anbd + p_bnad;
        rd = p_adbd;
        er = both || (p_adbd == '0);
      end
      OP_MUL: begin
        rn = p_anbn;
        rd = p_adbd;
        er = both || (p_adbd == '0);
      end
      OP_DIV: begin
        rn = p_anbd;
        rd = p_bnad;
        er = both || (bn == '0) || (p_bnad == '0);
      end
      OP_GT: begin
        tr = gtv;
        er = both;
      end
      OP_LT: begin
        tr = !eqv && !gtv;
        er = both;
      end
      OP_EQ: begin
        tr = eqv;
        er = both;
      end
      OP_NE: begin
        tr = !eqv;
        er = both;
      end
      OP_REDUCE: begin
        rn = ra_n;
        rd = ra_d;
        er = (ad == '0);
      end
      OP_INC: begin
        rn = an + ad;
        rd = ad;
        er = (ad == '0);
      end
      OP_DEC: begin
        rn = an - ad;
        rd = ad;
        er = (ad == '0);
      end
      OP_TO_INT: begin
        rn = q_int;
        er = (ad == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_num <= FIELD_BITS'(rn);
      res_den <= FIELD_BITS'(rd);
      truth   <= tr;
      error   <= er;
    end
  end

  assign status.mul_done = mul_done;
  assign status.div_done = div_done;
  assign status.y_zero   = (y == '0);
  assign status.op       = op;

endmodule

`default_nettype wire

// File: sv/rfa_ctrl.sv
// Controller state machine: handshakes, multiply sequence, Euclid reduction
// loop and result hand-off. Depends on rfa_pkg.
`default_nettype none

module rfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  rfa_pkg::rfa_status_t status,
  output rfa_pkg::rfa_cmd_t    cmd
);

  import rfa_pkg::*;

  rfa_state_t state, state_next;
  logic [1:0] idx, idx_next;
  logic       side, side_next;
  logic       out_free;

  function automatic mul_sel_t mul_pick(input logic [OP_BITS-1:0] o, input logic [1:0] i);
    mul_sel_t s;
    if (o == OP_MUL) begin
      s = (i == 2'd0) ? MS_AN_BN : MS_AD_BD;
    end else begin
      s = (i == 2'd0) ? MS_AN_BD : (i == 2'd1) ? MS_BN_AD : MS_AD_BD;
    end
    return s;
  endfunction

  function automatic logic mul_last(input logic [OP_BITS-1:0] o, input logic [1:0] i);
    return ((o == OP_ADD) || (o == OP_SUB)) ? (i == 2'd2) : (i == 2'd1);
  endfunction

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      side     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      side  <= side_next;
      if (cmd.capture) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    side_next  = side;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_next  = '0;
        side_next = 1'b0;
        unique case (status.op)
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT: state_next = S_MUL_GO;
          OP_EQ, OP_NE, OP_REDUCE:                      state_next = S_EUC_INIT;
          OP_TO_INT: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DS_AN_AD;
            state_next  = S_INT_WAIT;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_MUL_GO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = mul_pick(status.op, idx);
        state_next  = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (status.mul_done) begin
          if (!mul_last(status.op, idx)) begin
            idx_next   = idx + 2'd1;
            state_next = S_MUL_GO;
          end else if (status.op == OP_LT) begin
            state_next = S_EUC_INIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_EUC_INIT: begin
        cmd.euc_init = 1'b1;
        cmd.euc_side = side;
        state_next   = S_EUC_TEST;
      end
      S_EUC_TEST: begin
        cmd.div_go = 1'b1;
        if (status.y_zero) begin
          cmd.div_sel = side ? DS_BN_G : DS_AN_G;
          state_next  = S_QN_WAIT;
        end else begin
          cmd.div_sel = DS_XY;
          state_next  = S_STEP_WAIT;
        end
      end
      S_STEP_WAIT: begin
        if (status.div_done) begin
          state_next = S_EUC_TEST;
        end
      end
      S_QN_WAIT: begin
        if (status.div_done) begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = side ? DS_BD_G : DS_AD_G;
          state_next  = S_QD_WAIT;
        end
      end
      S_QD_WAIT: begin
        if (status.div_done) begin
          if (!side && (status.op != OP_REDUCE)) begin
            side_next  = 1'b1;
            state_next = S_EUC_INIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_INT_WAIT: begin
        if (status.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTH
  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!m_tvalid || m_tready))
    else $error("result captured over an unaccepted transaction");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_go && cmd.div_go))
    else $error("multiplier and divider started together");

  a_load_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DISPATCH))
    else $error("load not followed by dispatch");

  a_mul_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.mul_done |-> (state == S_MUL_WAIT))
    else $error("product finished while not awaited");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_STEP_WAIT || state == S_QN_WAIT ||
                         state == S_QD_WAIT || state == S_INT_WAIT))
    else $error("quotient finished while not awaited");
`endif

endmodule

`default_nettype wire

// File: sv/rational_fraction_alu.sv
// Rational fraction ALU: add, sub, mul, div, compares, reduce, inc, dec and
// integer conversion on two fractions of 32-bit signed parts.
//
// Input channel s_*: one transaction carries the operation in s_tuser and the
// two fractions in s_tdata. Output channel m_*: one transaction per input,
// with the result fraction and truth flag in m_tdata and the error flag in
// m_tuser. One item is processed at a time; s_tready is high only when idle.
// Work per operation, with bit-serial multiply and divide over W = WORD_BITS:
//   inc, dec, unused codes: no multiply or divide; to_int: one divide;
//   add, sub: 3 products; mul, div, gt: 2 products;
//   reduce: one Euclid reduction, its remainder steps then two divides, steps up to about 1.5*W;
//   eq, ne: two reductions; lt: two products plus two reductions.
// Throughput is set by the shared bit-serial multiplier and divider and by the
// Euclid remainder loop.
// A finished result sits in the output register; the next input is accepted
// while it waits, and only the following hand-off stalls on m_tready.
// Reset (rst, synchronous) returns the controller to idle and drops m_tvalid.
`default_nettype none

module rational_fraction_alu #(
  parameter int WORD_BITS = rfa_pkg::WORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // a_num, a_den, b_num, b_den
  input  logic [rfa_pkg::S_DATA_BITS-1:0]  s_tdata,
  // operation
  input  logic [rfa_pkg::OP_BITS-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // res_num, res_den, truth, zero pad
  output logic [rfa_pkg::M_DATA_BITS-1:0]  m_tdata,
  // error
  output logic                             m_tuser
);

  import rfa_pkg::*;

  rfa_cmd_t    cmd;
  rfa_status_t status;

  logic signed [FIELD_BITS-1:0] res_num, res_den;
  logic                         truth;

  rfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rfa_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .operation (s_tuser),
    .a_num     (s_tdata[FIELD_BITS-1:0]),
    .a_den     (s_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .b_num     (s_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
    .b_den     (s_tdata[4*FIELD_BITS-1:3*FIELD_BITS]),
    .res_num   (res_num),
    .res_den   (res_den),
    .truth     (truth),
    .error     (m_tuser)
  );

  assign m_tdata = {{M_PAD_BITS{1'b0}}, truth, res_den, res_num};

endmodule

`default_nettype wire

// File: tb/rational_fraction_alu_checker.sv
// Checker for the rational fraction ALU: watches both stream channels, predicts
// each result from the accepted operands and compares it field by field.
// Depends on rfa_pkg for operation codes and channel widths.
`timescale 1ns / 1ps

module rational_fraction_alu_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rfa_pkg::S_DATA_BITS-1:0] s_tdata,
  input  logic [rfa_pkg::OP_BITS-1:0]     s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rfa_pkg::M_DATA_BITS-1:0] m_tdata,
  input  logic                            m_tuser,
  output int                              fail_count,
  output int                              accepted_count,
  output int                              checked_count
);
  import rfa_pkg::*;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        truth;
    logic        error;
  } frac_result_t;

  frac_result_t expected_results[$];

  function automatic logic [63:0] magnitude(logic [31:0] v);
    logic [63:0] x;
    x = {{32{v[31]}}, v};
    return v[31] ? -x : x;
  endfunction

  // truncating division and remainder; zero divisor gives 0
  function automatic logic [31:0] trunc_div(logic [31:0] a, logic [31:0] b);
    logic [63:0] q;
    if (b == 0) return 32'd0;
    q = magnitude(a) / magnitude(b);
    if (a[31] ^ b[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
    logic [63:0] r;
    if (b == 0) return 32'd0;
    r = magnitude(a) % magnitude(b);
    if (a[31]) r = -r;
    return r[31:0];
  endfunction

  // {den, num} after division by the Euclid gcd
  function automatic logic [63:0] reduce_frac(logic [31:0] n, logic [31:0] d);
    logic [31:0] x, y, t;
    x = n;
    y = d;
    while (y != 0) begin
      t = trunc_rem(x, y);
      x = y;
      y = t;
    end
    return {trunc_div(d, x), trunc_div(n, x)};
  endfunction

  function automatic logic fractions_equal(logic [31:0] an, logic [31:0] ad,
                                           logic [31:0] bn, logic [31:0] bd);
    return reduce_frac(an, ad) == reduce_frac(bn, bd);
  endfunction

  function automatic frac_result_t compute_fraction_op(logic [3:0] op,
      logic [31:0] an, logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    frac_result_t r;
    logic [31:0]  nbd, x, y;
    logic [63:0]  red;
    logic         zero_den;
    r = '{num: 32'd0, den: 32'd1, truth: 1'b0, error: 1'b0};
    zero_den = (ad == 0) || (bd == 0);
    x = an * bd;
    y = bn * ad;
    case (op)
      OP_ADD: begin
        r.num = x + y;
        r.den = ad * bd;
        r.error = zero_den || (r.den == 0);
      end
      OP_SUB: begin
        nbd = -bd;
        r.num = an * nbd + y;
        r.den = ad * nbd;
        r.error = zero_den || (r.den == 0);
      end
      OP_MUL: begin
        r.num = an * bn;
        r.den = ad * bd;
        r.error = zero_den || (r.den == 0);
      end
      OP_DIV: begin
        r.num = bd * an;
        r.den = bn * ad;
        r.error = zero_den || (bn == 0) || (r.den == 0);
      end
      OP_GT: begin
        r.truth = $signed(x) > $signed(y);
        r.error = zero_den;
      end
      OP_LT: begin
        r.truth = !fractions_equal(an, ad, bn, bd) && !($signed(x) > $signed(y));
        r.error = zero_den;
      end
      OP_EQ: begin
        r.truth = fractions_equal(an, ad, bn, bd);
        r.error = zero_den;
      end
      OP_NE: begin
        r.truth = !fractions_equal(an, ad, bn, bd);
        r.error = zero_den;
      end
      OP_REDUCE: begin
        red = reduce_frac(an, ad);
        r.num = red[31:0];
        r.den = red[63:32];
        r.error = (ad == 0);
      end
      OP_INC: begin
        r.num = an + ad;
        r.den = ad;
        r.error = (ad == 0);
      end
      OP_DEC: begin
        r.num = an - ad;
        r.den = ad;
        r.error = (ad == 0);
      end
      OP_TO_INT: begin
        r.num = trunc_div(an, ad);
        r.error = (ad == 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    frac_result_t got, want;
    int           bad;
    bad = 0;
    if (rst) begin
      expected_results.delete();
      fail_count     <= 0;
      accepted_count <= 0;
      checked_count  <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.num   = m_tdata[31:0];
        got.den   = m_tdata[63:32];
        got.truth = m_tdata[64];
        got.error = m_tuser;
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with none pending, actual num %h den %h",
                   $time, got.num, got.den);
          bad = 1;
        end else begin
          want = expected_results.pop_front();
          bad += field_mismatch("res_num", want.num, got.num);
          bad += field_mismatch("res_den", want.den, got.den);
          bad += field_mismatch("truth", 32'(want.truth), 32'(got.truth));
          bad += field_mismatch("error", 32'(want.error), 32'(got.error));
          checked_count <= checked_count + 1;
        end
        fail_count <= fail_count + bad;
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(compute_fraction_op(s_tuser, s_tdata[31:0],
            s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]));
        accepted_count <= accepted_count + 1;
      end
    end
  end

endmodule

// File: tb/rational_fraction_alu_tb.sv
// Top of the rational fraction ALU testbench: clock, reset, directed and random
// operand transactions under several idle patterns, and the final verdict.
// Depends on rfa_pkg, rational_fraction_alu and rational_fraction_alu_checker.
`timescale 1ns / 1ps

module rational_fraction_alu_tb;
  import rfa_pkg::*;

  localparam int          CYCLE_LIMIT  = 25_000_000;
  localparam int          PHASE_ITEMS  = 375;
  localparam logic [31:0] W_MIN        = 32'h8000_0000;
  localparam logic [31:0] W_MAX        = 32'h7fff_ffff;
  localparam logic [31:0] W_NEG1       = 32'hffff_ffff;
  localparam logic [3:0]  OP_UNUSED_LO = 4'd12;
  localparam logic [3:0]  OP_UNUSED_HI = 4'd15;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_DATA_BITS-1:0] s_tdata;
  logic [OP_BITS-1:0]     s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_DATA_BITS-1:0] m_tdata;
  logic                   m_tuser;

  int fail_count, accepted_count, checked_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  rational_fraction_alu uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  rational_fraction_alu_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .accepted_count(accepted_count),
    .checked_count(checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic [3:0] op, input logic [31:0] an,
                           input logic [31:0] ad, input logic [31:0] bn,
                           input logic [31:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {bd, bn, ad, an};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (accepted_count != checked_count) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(40) - 20;
      7: begin
        case ($urandom_range(4))
          0:       return 32'd0;
          1:       return 32'd1;
          2:       return W_NEG1;
          3:       return W_MIN;
          default: return W_MAX;
        endcase
      end
      8:       return 32'd1 << $urandom_range(31);
      default: return {{16{h[15]}}, h};
    endcase
  endfunction

  task automatic send_random_item();
    logic [3:0]  op;
    logic [31:0] an, ad, bn, bd;
    int          n, d, k1, k2;
    op = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(OP_TO_INT));
    an = rand_word();
    ad = rand_word();
    bn = rand_word();
    bd = rand_word();
    case ($urandom_range(7))
      4, 5: begin
        // same fraction scaled two ways, so equality and reduction do real work
        n  = $urandom_range(30) - 15;
        d  = $urandom_range(29) + 1;
        if ($urandom_range(1)) d = -d;
        k1 = $urandom_range(999) + 1;
        k2 = $urandom_range(999) + 1;
        if ($urandom_range(3) == 0) k1 = -k1;
        if ($urandom_range(3) == 0) k2 = -k2;
        an = n * k1;
        ad = d * k1;
        bn = n * k2;
        bd = d * k2;
      end
      6: begin
        bn = an;
        bd = ad;
      end
      7: begin
        case ($urandom_range(2))
          0:       ad = 32'd0;
          1:       bd = 32'd0;
          default: bn = 32'd0;
        endcase
      end
      default: ;
    endcase
    send_item(op, an, ad, bn, bd);
  endtask

  initial begin
    int sender_pct[4];
    int receiver_pct[4];
    sender_pct   = '{0, 60, 0, 9};
    receiver_pct = '{0, 0, 60, 9};
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(OP_ADD, 32'd65536, 32'd65536, 32'd1, 32'd65536);
    send_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    send_item(OP_SUB, W_MIN, W_NEG1, 32'd1, W_MIN);
    send_item(OP_MUL, W_MIN, W_MIN, W_MIN, W_NEG1);
    send_item(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_item(OP_DIV, W_MAX, W_MIN, W_NEG1, W_MAX);
    send_item(OP_GT, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(OP_GT, W_NEG1, 32'd1, 32'd0, 32'd0);
    send_item(OP_LT, 32'd1, 32'd3, 32'd1, 32'd2);
    send_item(OP_EQ, 32'd2, 32'd4, -32'sd3, -32'sd6);
    send_item(OP_EQ, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(OP_NE, 32'd2, 32'd4, 32'd1, 32'd2);
    send_item(OP_REDUCE, 32'd0, 32'd0, W_MAX, W_MIN);
    send_item(OP_REDUCE, 32'd12, -32'sd18, 32'd0, 32'd0);
    send_item(OP_REDUCE, W_MIN, W_NEG1, 32'd0, 32'd1);
    send_item(OP_INC, W_MAX, 32'd1, 32'd0, 32'd0);
    send_item(OP_DEC, W_MIN, 32'd1, 32'd0, 32'd0);
    send_item(OP_INC, 32'd5, 32'd0, 32'd0, 32'd0);
    send_item(OP_TO_INT, W_MIN, W_NEG1, 32'd0, 32'd0);
    send_item(OP_TO_INT, 32'd7, 32'd0, 32'd0, 32'd0);
    for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
      send_item(4'(c), W_NEG1, W_NEG1, W_NEG1, W_NEG1);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = sender_pct[ph];
      recv_stall_pct = receiver_pct[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
      if (ph == 1) wait_drained();
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("Summary: %0d operand transactions, directed extremes plus random mix",
             accepted_count);
    $display("  over all sixteen codes and four idle patterns; %0d results compared",
             checked_count);
    if (fail_count == 0 && accepted_count == checked_count) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rfa_pkg.sv
sv/rfa_mul.sv
sv/rfa_div.sv
sv/rfa_datapath.sv
sv/rfa_ctrl.sv
sv/rational_fraction_alu.sv
tb/rational_fraction_alu_checker.sv
tb/rational_fraction_alu_tb.sv
